FILE: hw/rtl/lsc_pkg.sv
package lsc_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int MAX_RESULTS = 3;

	typedef enum logic [3:0] {
		ST_EMPTY = 4'd0,
		ST_SIGN  = 4'd1,
		ST_SINT  = 4'd2,
		ST_SDEC  = 4'd3,
		ST_UINT  = 4'd4,
		ST_UDEC  = 4'd5,
		ST_USCI  = 4'd6,
		ST_USTR  = 4'd7,
		ST_NAME  = 4'd8,
		ST_UNK   = 4'd9
	} lex_state_t;

	typedef enum logic [1:0] {
		LA_NONE = 2'd0,
		LA_DOT  = 2'd1,
		LA_E    = 2'd2
	} look_t;

	typedef enum logic [1:0] {
		H_NONE  = 2'd0,
		H_ANGLE = 2'd1,
		H_BANG  = 2'd3
	} hold_t;

	localparam logic [3:0] CLS_REL   = 4'd0;
	localparam logic [3:0] CLS_SINT  = 4'd1;
	localparam logic [3:0] CLS_UINT  = 4'd2;
	localparam logic [3:0] CLS_DEC   = 4'd3;
	localparam logic [3:0] CLS_SCI   = 4'd4;
	localparam logic [3:0] CLS_STR   = 4'd5;
	localparam logic [3:0] CLS_NAME  = 4'd6;
	localparam logic [3:0] CLS_UNK   = 4'd7;
	localparam logic [3:0] CLS_EMPTY = 4'd8;

	typedef struct packed {
		logic [7:0] byte_req;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  token_class;
		logic [15:0] line_number;
		logic [15:0] token_length;
		logic        last_of_run;
	} out_item_t;

endpackage

FILE: hw/rtl/lsc_stream_if.sv
interface lsc_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/lexeme_splitter_classifier_top.sv
// channel | dir | payload                                              | transfer
// bytes   | in  | byte_req[7:0], last                                  | valid & ready
// tokens  | out | token_class[3:0], line_number, token_length, last_of_run | valid & ready
//
// one byte is taken per cycle; its results are computed in that cycle and land in
// a four-entry result queue, leaving one result per cycle on the tokens side
// bytes.ready is high while the queue has room for three results, so a byte that
// yields zero or one result per cycle streams at full rate
// a byte giving two or three results, or a stalled tokens side, holds bytes.ready low
// until at most one result is left in the queue
// arst_n clears the classifier state and queue and sets the line counter to one

module lexeme_splitter_classifier_top
	import lsc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	lsc_stream_if.sink       bytes,
	lsc_stream_if.source     tokens
);

	localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);
	localparam int NCAND = 8;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	typedef logic [CW-1:0] cnt_t;

	localparam cnt_t CNT_MAX = {CW{1'b1}};
	localparam cnt_t CNT_ONE = cnt_t'(1);

	typedef struct packed {
		lex_state_t st;
		look_t      la;
		cnt_t       len;
	} lex_t;

	localparam lex_t LEX_RESET = '{st: ST_EMPTY, la: LA_NONE, len: '0};

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_sign(logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	function automatic lex_t feed(lex_t s, logic [7:0] c);
		lex_t r;
		logic done;
		r = s;
		done = 1'b0;
		r.len = sat_inc(s.len);
		if (s.la == LA_DOT) begin
			r.la = LA_NONE;
			if (is_digit(c)) begin
				r.st = (s.st == ST_SINT) ? ST_SDEC : ST_UDEC;
				done = 1'b1;
			end else begin
				r.st = ST_UNK;
			end
		end else if (s.la == LA_E) begin
			r.la = LA_NONE;
			if (is_sign(c)) begin
				r.st = (s.st == ST_UINT || s.st == ST_UDEC) ? ST_USCI : ST_UNK;
				done = 1'b1;
			end else if (s.st == ST_UINT) begin
				r.st = ST_USTR;
			end
		end
		if (!done) begin
			case (r.st) inside
				ST_EMPTY: begin
					if (is_sign(c))       r.st = ST_SIGN;
					else if (is_digit(c)) r.st = ST_UINT;
					else if (is_alpha(c)) r.st = ST_NAME;
					else                  r.st = ST_UNK;
				end
				ST_SIGN: r.st = is_digit(c) ? ST_SINT : ST_UNK;
				ST_SINT: begin
					if (c == CH_DOT)      r.la = LA_DOT;
					else if (!is_digit(c)) r.st = ST_UNK;
				end
				ST_SDEC: begin
					if (!is_digit(c)) r.st = ST_UNK;
				end
				ST_UINT, ST_UDEC, ST_USCI, ST_USTR: begin
					if (c == CH_DOT) begin
						if (r.st == ST_UINT) r.la = LA_DOT;
						else                 r.st = ST_UNK;
					end else if (c == CH_E) begin
						r.la = LA_E;
					end else if (is_alpha(c)) begin
						if (r.st == ST_UINT) r.st = ST_USTR;
					end else if (!is_digit(c)) begin
						r.st = ST_UNK;
					end
				end
				ST_NAME: begin
					if (!is_alpha(c) && !is_digit(c)) r.st = ST_UNK;
				end
				default: r.st = ST_UNK;
			endcase
		end
		return r;
	endfunction

	function automatic logic [3:0] fin_class(lex_t s);
		lex_state_t st;
		logic [3:0] cls;
		st = s.st;
		if (s.la == LA_DOT)                          st = ST_UNK;
		else if (s.la == LA_E && st == ST_UINT)      st = ST_USTR;
		case (st)
			ST_SINT: cls = CLS_SINT;
			ST_SDEC: cls = CLS_DEC;
			ST_UINT: cls = CLS_UINT;
			ST_UDEC: cls = CLS_DEC;
			ST_USCI: cls = CLS_SCI;
			ST_USTR: cls = CLS_STR;
			ST_NAME: cls = CLS_NAME;
			default: cls = CLS_UNK;
		endcase
		return cls;
	endfunction

	function automatic out_item_t mk_item(logic [3:0] cls, cnt_t line, logic [15:0] len);
		out_item_t it;
		it.token_class  = cls;
		it.line_number  = 16'(line);
		it.token_length = len;
		it.last_of_run  = 1'b0;
		return it;
	endfunction

	lex_t      lex_q, lex_d;
	hold_t     hold_q, hold_d;
	cnt_t      line_q, line_d;
	logic      seen_q, seen_d;

	out_item_t cand [NCAND];
	logic      cv   [NCAND];
	out_item_t slot [MAX_RESULTS];
	logic [1:0] nres;

	out_item_t       fifo_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   count_q;

	logic acc, pop;
	logic [7:0] b;

	assign b   = bytes.data.byte_req;
	assign acc = bytes.valid && bytes.ready;
	assign pop = tokens.valid && tokens.ready;

	assign bytes.ready  = (count_q <= NW'(FIFO_DEPTH - MAX_RESULTS));
	assign tokens.valid = (count_q != '0);
	assign tokens.data  = fifo_q[rd_ptr_q];

	// per-byte step: held operator, then the byte, then end-of-input flush
	always_comb begin
		lex_t lx;
		hold_t hold;
		cnt_t line;
		logic skip_b;
		logic any_emit;
		lx     = lex_q;
		hold   = hold_q;
		line   = line_q;
		skip_b = 1'b0;
		for (int i = 0; i < NCAND; i++) begin
			cand[i] = '0;
			cv[i]   = 1'b0;
		end

		if (hold == H_BANG) begin
			hold = H_NONE;
			if (b == CH_EQ) begin
				cv[0]   = (lx.len != '0);
				cand[0] = mk_item(fin_class(lx), line, 16'(lx.len));
				lx      = LEX_RESET;
				cv[1]   = 1'b1;
				cand[1] = mk_item(CLS_REL, line, 16'd2);
				skip_b  = 1'b1;
			end else begin
				lx = feed(lx, CH_BANG);
			end
		end else if (hold != H_NONE) begin
			hold = H_NONE;
			if (b == CH_EQ) begin
				cv[1]   = 1'b1;
				cand[1] = mk_item(CLS_REL, line, 16'd2);
				skip_b  = 1'b1;
			end else begin
				cv[2]   = 1'b1;
				cand[2] = mk_item(CLS_REL, line, 16'd1);
			end
		end

		if (!skip_b) begin
			case (b) inside
				CH_SPACE, CH_TAB, CH_NL, CH_LT, CH_GT, CH_EQ, CH_LBRK, CH_RBRK,
				CH_LBRC, CH_RBRC, CH_LPAR, CH_RPAR, CH_SEMI: begin
					cv[3]   = (lx.len != '0);
					cand[3] = mk_item(fin_class(lx), line, 16'(lx.len));
					lx      = LEX_RESET;
					if (b == CH_NL) begin
						line = sat_inc(line);
					end else if (b == CH_LT || b == CH_GT) begin
						hold = H_ANGLE;
					end else if (b != CH_SPACE && b != CH_TAB) begin
						cv[4]   = 1'b1;
						cand[4] = mk_item((b == CH_EQ) ? CLS_REL : CLS_UNK, line, 16'd1);
					end
				end
				CH_BANG: hold = H_BANG;
				default: lx = feed(lx, b);
			endcase
		end

		if (bytes.data.last) begin
			if (hold == H_BANG) begin
				lx = feed(lx, CH_BANG);
			end else if (hold != H_NONE) begin
				cv[5]   = 1'b1;
				cand[5] = mk_item(CLS_REL, line, 16'd1);
			end
			cv[6]   = (lx.len != '0);
			cand[6] = mk_item(fin_class(lx), line, 16'(lx.len));
			any_emit = seen_q;
			for (int i = 0; i < NCAND - 1; i++) any_emit = any_emit | cv[i];
			cv[7]   = !any_emit;
			cand[7] = mk_item(CLS_EMPTY, line, 16'd0);
			lex_d   = LEX_RESET;
			hold_d  = H_NONE;
			line_d  = CNT_ONE;
			seen_d  = 1'b0;
		end else begin
			any_emit = seen_q;
			for (int i = 0; i < NCAND; i++) any_emit = any_emit | cv[i];
			lex_d  = lx;
			hold_d = hold;
			line_d = line;
			seen_d = any_emit;
		end
	end

	// pack the first three results in order, mark the final one
	always_comb begin
		logic [1:0] k;
		k = 2'd0;
		for (int j = 0; j < MAX_RESULTS; j++) slot[j] = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cv[i] && k < 2'(MAX_RESULTS)) begin
				slot[k] = cand[i];
				k = k + 2'd1;
			end
		end
		for (int j = 0; j < MAX_RESULTS; j++) slot[j].last_of_run = (2'(j) == k - 2'd1);
		nres = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q  <= LEX_RESET;
			hold_q <= H_NONE;
			line_q <= CNT_ONE;
			seen_q <= 1'b0;
		end else if (acc) begin
			lex_q  <= lex_d;
			hold_q <= hold_d;
			line_q <= line_d;
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int j = 0; j < MAX_RESULTS; j++) begin
				if (2'(j) < nres) fifo_q[wr_ptr_q + PW'(j)] <= slot[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (acc) wr_ptr_q <= wr_ptr_q + PW'(nres);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + (acc ? NW'(nres) : NW'(0)) - (pop ? NW'(1) : NW'(0));
		end
	end

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && bytes.data.last && !seen_q |-> nres != 2'd0)
		else $error("end of input transfer with no earlier token produced no result");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc && bytes.data.last |=> line_q == CNT_ONE && hold_q == H_NONE && !seen_q
			&& lex_q.len == '0)
		else $error("state not cleared after end of input");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		!acc && !pop |=> $stable(count_q))
		else $error("queue count moved without a transfer");

endmodule
